// ===== rtl/lgs_pkg.sv =====
// Shared constants, types and rule functions for the life generation stencil.
`default_nettype none
package lgs_pkg;

  localparam int MAX_COLS   = 63;
  localparam int MAX_ROWS   = 1024;
  localparam int COL_W      = $clog2(MAX_COLS + 1);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int LS_W       = 2;
  localparam int LS_DEPTH   = MAX_COLS;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_ROOM  = FIFO_DEPTH - 4;

  localparam logic [CFG_IDX_W-1:0]  REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_COLS = CFG_IDX_W'(1);
  localparam logic [ROWS_CFG_W-1:0] RESET_ROWS    = ROWS_CFG_W'(32);
  localparam logic [COLS_CFG_W-1:0] RESET_COLS    = COLS_CFG_W'(32);

  typedef logic [8:0] win_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic next_alive;
    logic frame_last;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic             bit_in;
    logic             row_ge1;
    logic             row_ge2;
    logic [COL_W-1:0] col;
    logic             col_first;
    logic             col_last;
  } s1_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } fl_rd_t;

  function automatic win_t shift_in(input win_t w, input logic top, input logic mid,
                                    input logic bot);
    win_t n;
    n = (w >> 1) & 9'h0DB;
    n[2] = top;
    n[5] = mid;
    n[8] = bot;
    return n;
  endfunction

  function automatic logic life_rule(input win_t w);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) cnt = cnt + 4'(w[k]);
    end
    if (w[4]) return (cnt == 4'd2) || (cnt == 4'd3);
    return cnt == 4'd3;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lgs_if.sv =====
// Channel interfaces: cell requests, result requests and register writes.
`default_nettype none
interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;
  modport source(output valid, output cell_alive, input ready);
  modport sink(input valid, input cell_alive, output ready);
endinterface

interface lgs_result_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic frame_last;
  modport source(output valid, output next_alive, output frame_last, input ready);
  modport sink(input valid, input next_alive, input frame_last, output ready);
endinterface

interface lgs_cfg_if;
  import lgs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lgs_window.sv =====
// Window datapath: line store update, rule evaluation, row tail and final row flush.
`default_nettype none
module lgs_window (
  input  logic                  clk,
  input  logic                  rst,
  input  lgs_pkg::s1_t          s1,
  input  lgs_pkg::fl_rd_t       fl,
  input  logic [lgs_pkg::LS_W-1:0] rd_data,
  output logic                  ls_we,
  output logic [lgs_pkg::COL_W-1:0] ls_waddr,
  output logic [lgs_pkg::LS_W-1:0]  ls_wdata,
  output logic                  push,
  output lgs_pkg::result_t      push_data
);
  import lgs_pkg::*;

  win_t    window;
  win_t    fwin;
  logic    tail_valid;
  result_t tail;
  win_t    win_next;
  win_t    fwin_next;
  logic    top_b;
  logic    mid_b;
  logic    tail_set;
  result_t tail_next;

  always_comb begin
    top_b     = s1.row_ge2 & rd_data[0];
    mid_b     = s1.row_ge1 & rd_data[1];
    win_next  = shift_in(s1.col_first ? '0 : window, top_b, mid_b, s1.bit_in);
    fwin_next = shift_in(fl.first ? '0 : fwin, rd_data[0], rd_data[1], 1'b0);

    ls_we    = s1.valid;
    ls_waddr = s1.col;
    ls_wdata = {s1.bit_in, mid_b};

    push      = 1'b0;
    push_data = '0;
    priority if (tail_valid) begin
      push      = 1'b1;
      push_data = tail;
    end else if (s1.valid && s1.row_ge1 && !s1.col_first) begin
      push                 = 1'b1;
      push_data.next_alive = life_rule(win_next);
    end else if (fl.valid && !fl.first) begin
      push                 = 1'b1;
      push_data.next_alive = life_rule(fwin_next);
    end

    tail_set  = 1'b0;
    tail_next = '0;
    priority if (s1.valid && s1.row_ge1 && s1.col_last) begin
      tail_set             = 1'b1;
      tail_next.next_alive = life_rule(shift_in(win_next, 1'b0, 1'b0, 1'b0));
    end else if (fl.valid && fl.last) begin
      tail_set             = 1'b1;
      tail_next.next_alive = life_rule(shift_in(fwin_next, 1'b0, 1'b0, 1'b0));
      tail_next.frame_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_valid <= 1'b0;
      window     <= '0;
    end else begin
      tail_valid <= tail_set;
      if (s1.valid) window <= win_next;
    end
    tail <= tail_next;
    if (fl.valid) fwin <= fwin_next;
  end

endmodule
`default_nettype wire

// ===== rtl/lgs_out_fifo.sv =====
// Result queue between the window datapath and the result channel.
`default_nettype none
module lgs_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lgs_pkg::result_t push_data,
  output logic             room,
  lgs_result_if.source     results
);
  import lgs_pkg::*;

  result_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic                   pop;

  assign pop                = results.valid && results.ready;
  assign results.valid      = count != '0;
  assign results.next_alive = mem[rd_ptr].next_alive;
  assign results.frame_last = mem[rd_ptr].frame_last;
  assign room               = count <= FIFO_CNT_W'(FIFO_ROOM);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ===== rtl/life_generation_stencil_core.sv =====
// Top level: B3/S23 next-generation stencil over a row-major cell stream.
// Throughput: one cell per cycle while the result queue has room; after the last
//   cell of a frame the final row is read back from the line store column by column,
//   and no cell is taken meanwhile.
// Results: the result for cell (r,c) is queued, then offered, once cell (r+1,c+1) is taken.
// Reset: synchronous; clears counters, queue and sequencer, sets a 32 x 32 grid.
`default_nettype none
module life_generation_stencil_core (
  input  logic         clk,
  input  logic         rst,
  lgs_cell_if.sink     cells,
  lgs_result_if.source results,
  lgs_cfg_if.sink      cfg
);
  import lgs_pkg::*;

  logic [ROWS_CFG_W-1:0] grid_rows;
  logic [COLS_CFG_W-1:0] grid_cols;
  logic [ROW_W-1:0]      last_row;
  logic [COL_W-1:0]      last_col;
  logic [ROW_W-1:0]      row_count;
  logic [COL_W-1:0]      col_count;
  logic [COL_W-1:0]      fl_col;
  logic [COL_W-1:0]      fl_col_next;
  state_t                state;
  state_t                state_next;
  s1_t                   s1;
  fl_rd_t                fl_rd;
  logic                  room;
  logic                  cell_acc;
  logic                  cfg_acc;
  logic                  frame_end;
  logic                  fl_issue;
  logic                  rd_en;
  logic [COL_W-1:0]      rd_addr;
  logic [LS_W-1:0]       rd_data;
  logic                  ls_we;
  logic [COL_W-1:0]      ls_waddr;
  logic [LS_W-1:0]       ls_wdata;
  logic                  push;
  result_t               push_data;

  assign cfg.ready   = 1'b1;
  assign cfg_acc     = cfg.valid && cfg.ready;
  assign cells.ready = (state == ST_RUN) && room;
  assign cell_acc    = cells.valid && cells.ready;
  assign frame_end   = (row_count == last_row) && (col_count == last_col);
  assign rd_en       = cell_acc || fl_issue;
  assign rd_addr     = (state == ST_FLUSH) ? fl_col : col_count;

  always_comb begin
    if (grid_rows < ROWS_CFG_W'(2)) last_row = ROW_W'(1);
    else if (grid_rows > ROWS_CFG_W'(MAX_ROWS)) last_row = ROW_W'(MAX_ROWS - 1);
    else last_row = ROW_W'(grid_rows - ROWS_CFG_W'(1));
    if (grid_cols < COLS_CFG_W'(2)) last_col = COL_W'(1);
    else if ({1'b0, grid_cols} > (COLS_CFG_W + 1)'(MAX_COLS)) last_col = COL_W'(MAX_COLS - 1);
    else last_col = COL_W'(grid_cols - COLS_CFG_W'(1));
  end

  always_comb begin
    state_next  = state;
    fl_col_next = fl_col;
    fl_issue    = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (cell_acc && frame_end) begin
          state_next  = ST_FLUSH;
          fl_col_next = '0;
        end
      end
      ST_FLUSH: begin
        if (room) begin
          fl_issue = 1'b1;
          if (fl_col == last_col) state_next = ST_RUN;
          else fl_col_next = fl_col + COL_W'(1);
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      fl_col <= '0;
    end else if (cfg_acc) begin
      state <= ST_RUN;
      fl_col <= '0;
    end else begin
      state <= state_next;
      fl_col <= fl_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= RESET_ROWS;
      grid_cols <= RESET_COLS;
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_acc) begin
      unique case (cfg.index)
        REG_GRID_ROWS: grid_rows <= cfg.data[ROWS_CFG_W-1:0];
        REG_GRID_COLS: grid_cols <= cfg.data[COLS_CFG_W-1:0];
        default: ;
      endcase
      row_count <= '0;
      col_count <= '0;
    end else if (cell_acc) begin
      if (col_count == last_col) begin
        col_count <= '0;
        row_count <= (row_count == last_row) ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid    <= 1'b0;
      fl_rd.valid <= 1'b0;
    end else begin
      s1.valid    <= cell_acc;
      fl_rd.valid <= fl_issue;
    end
    s1.bit_in    <= cells.cell_alive;
    s1.row_ge1   <= row_count >= ROW_W'(1);
    s1.row_ge2   <= row_count >= ROW_W'(2);
    s1.col       <= col_count;
    s1.col_first <= col_count == '0;
    s1.col_last  <= col_count == last_col;
    fl_rd.first  <= fl_col == '0;
    fl_rd.last   <= fl_col == last_col;
  end

  lgs_ram #(
    .WIDTH(LS_W),
    .DEPTH(LS_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ls_we),
    .waddr(ls_waddr),
    .wdata(ls_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  lgs_window u_window (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .fl       (fl_rd),
    .rd_data  (rd_data),
    .ls_we    (ls_we),
    .ls_waddr (ls_waddr),
    .ls_wdata (ls_wdata),
    .push     (push),
    .push_data(push_data)
  );

  lgs_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .room     (room),
    .results  (results)
  );

endmodule
`default_nettype wire

// ===== rtl/lgs_checker.sv =====
// Port-level checks for the life generation stencil core, bound to the top level.
`default_nettype none
module lgs_checker (
  input logic clk,
  input logic rst,
  input logic cells_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_next_alive,
  input logic res_frame_last
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> cells_ready)
    else $error("cell request not taken after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_next_alive) &&
                                $stable(res_frame_last))
    else $error("stalled result request changed");

  a_single_frame_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_frame_last |=> !(res_valid && res_frame_last))
    else $error("two frame ends in a row");

endmodule

bind life_generation_stencil_core lgs_checker u_lgs_checker (
  .clk           (clk),
  .rst           (rst),
  .cells_ready   (cells.ready),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .res_next_alive(results.next_alive),
  .res_frame_last(results.frame_last)
);
`default_nettype wire

// ===== test/lgs_stencil_checker.sv =====
// Checker for the life generation stencil: next-generation prediction and result compare.
module lgs_stencil_checker (
  input  logic   clk,
  input  logic   rst,
  lgs_cell_if    cells,
  lgs_result_if  results,
  lgs_cfg_if     cfg,
  output int     failures,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lgs_pkg::*;

  logic [ROWS_CFG_W-1:0] rows_set;
  logic [COLS_CFG_W-1:0] cols_set;
  logic                  older_row [MAX_COLS];
  logic                  newer_row [MAX_COLS];
  win_t                  nbhd;
  int unsigned           row_at;
  int unsigned           col_at;
  result_t               gen_due [$];
  int                    err_count = 0;
  int unsigned           res_seen;

  assign failures = err_count;

  function automatic win_t slide(win_t w, logic t, logic m, logic b);
    return {b, w[8:7], m, w[5:4], t, w[2:1]};
  endfunction

  function automatic logic next_state(win_t w);
    int live;
    live = $countones(w & 9'h1EF);
    return w[4] ? (live == 2 || live == 3) : (live == 3);
  endfunction

  function automatic int unsigned span(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void queue_gen(logic alive, logic last);
    result_t r;
    r.next_alive = alive;
    r.frame_last = last;
    gen_due.push_back(r);
  endfunction

  function automatic void restart_frame();
    row_at = 0;
    col_at = 0;
    nbhd   = '0;
  endfunction

  function automatic void take_cell(logic alive);
    int unsigned nrows;
    int unsigned ncols;
    logic        up;
    logic        mid;
    win_t        w;
    nrows = span(rows_set, 2, MAX_ROWS);
    ncols = span(cols_set, 2, MAX_COLS);
    up  = (row_at >= 2) ? older_row[col_at] : 1'b0;
    mid = (row_at >= 1) ? newer_row[col_at] : 1'b0;
    if (col_at == 0) nbhd = '0;
    nbhd = slide(nbhd, up, mid, alive);
    older_row[col_at] = mid;
    newer_row[col_at] = alive;
    if (row_at >= 1 && col_at >= 1) queue_gen(next_state(nbhd), 1'b0);
    if (row_at >= 1 && col_at == ncols - 1)
      queue_gen(next_state(slide(nbhd, 1'b0, 1'b0, 1'b0)), 1'b0);
    if (row_at == nrows - 1 && col_at == ncols - 1) begin
      w = '0;
      for (int unsigned c = 0; c < ncols; c++) begin
        w = slide(w, older_row[c], newer_row[c], 1'b0);
        if (c >= 1) queue_gen(next_state(w), 1'b0);
      end
      queue_gen(next_state(slide(w, 1'b0, 1'b0, 1'b0)), 1'b1);
    end
    col_at++;
    if (col_at >= ncols) begin
      col_at = 0;
      row_at++;
      if (row_at >= nrows) row_at = 0;
    end
  endfunction

  task automatic flag(string what);
    $display("[%0t] mismatch on result %0d: %s", $time, res_seen, what);
    err_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rows_set = RESET_ROWS;
      cols_set = RESET_COLS;
      gen_due.delete();
      res_seen = 0;
      restart_frame();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_GRID_ROWS) begin
          rows_set = cfg.data[ROWS_CFG_W-1:0];
          restart_frame();
        end else if (cfg.index == REG_GRID_COLS) begin
          cols_set = cfg.data[COLS_CFG_W-1:0];
          restart_frame();
        end
      end
      if (cells.valid && cells.ready) take_cell(cells.cell_alive);
      if (results.valid && results.ready) begin
        if (gen_due.size() == 0) begin
          flag("result with nothing pending");
        end else begin
          want = gen_due.pop_front();
          if (results.next_alive !== want.next_alive)
            flag($sformatf("next_alive %b, predicted %b", results.next_alive,
                           want.next_alive));
          if (results.frame_last !== want.frame_last)
            flag($sformatf("frame_last %b, predicted %b", results.frame_last,
                           want.frame_last));
        end
        res_seen++;
      end
    end
    outstanding <= gen_due.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top: clock, reset, cell and register stimulus, result back-pressure, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgs_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 50000;
  localparam int DRAIN        = 16;
  localparam int LONG_HOLD    = 300;

  logic        clk;
  logic        rst;
  int          failures;
  int          outstanding;
  int unsigned cycles;
  bit          gaps_on;
  bit          hold_long;

  lgs_cell_if   cell_bus ();
  lgs_result_if result_bus ();
  lgs_cfg_if    cfg_bus ();

  life_generation_stencil_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .cells   (cell_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  lgs_stencil_checker i_chk (
    .clk         (clk),
    .rst         (rst),
    .cells       (cell_bus),
    .results     (result_bus),
    .cfg         (cfg_bus),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_cell(input logic alive);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cell_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cell_bus.valid      <= 1'b1;
    cell_bus.cell_alive <= alive;
    @(posedge clk);
    while (!cell_bus.ready) @(posedge clk);
  endtask

  task automatic run_cells(input int unsigned n, input int unsigned pct);
    repeat (n) send_cell($urandom_range(0, 99) < pct);
  endtask

  task automatic settle();
    cell_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_grid(input int unsigned nrows, input int unsigned ncols);
    write_reg(REG_GRID_ROWS, nrows);
    write_reg(REG_GRID_COLS, ncols);
  endtask

  initial begin
    logic [0:17]  pattern;
    int unsigned  r;
    int unsigned  c;
    rst                 <= 1'b1;
    cell_bus.valid      <= 1'b0;
    cell_bus.cell_alive <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= REG_GRID_ROWS;
    cfg_bus.data        <= '0;
    gaps_on   = 1'b1;
    hold_long = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // default 32 x 32 grid, partial frame
    run_cells(36, 40);

    // blinker, then a full block
    set_grid(3, 3);
    pattern = 18'b010_010_010_111_111_111;
    for (int k = 0; k < 18; k++) send_cell(pattern[k]);
    send_cell(1'b1);

    // sizes below range clamp to 2
    set_grid(0, 1);
    run_cells(5, 50);
    set_grid(1, 0);
    run_cells(5, 60);

    // widest rows overflow the per-cell result budget; stall the output meanwhile
    set_grid(2, 63);
    hold_long = 1'b1;
    run_cells(127, 35);

    // write mid-frame restarts it
    set_grid(3, 5);
    run_cells(4, 40);
    write_reg(REG_GRID_COLS, 5);
    run_cells(15, 40);

    // rows above range clamp to the maximum
    set_grid(2047, 2);
    run_cells(10, 30);

    for (int p = 0; p < 2; p++) begin
      r = $urandom_range(2, 3);
      c = $urandom_range(2, 4);
      set_grid(r, c);
      gaps_on = ($urandom_range(0, 3) != 0);
      run_cells(r * c + $urandom_range(0, c), $urandom_range(15, 60));
    end

    gaps_on = 1'b0;
    set_grid(3, 4);
    run_cells(12, 35);

    settle();
    if (failures == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
